// ----- src/farthest_first_pivot_select_defines.svh -----
// Assertion macros for the pivot select block.
`ifndef FARTHEST_FIRST_PIVOT_SELECT_DEFINES_SVH
`define FARTHEST_FIRST_PIVOT_SELECT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FFPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define FFPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FFPS_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define FFPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- src/ffps_pkg.sv -----
package ffps_pkg;

   localparam int MAX_OBJECTS = 4096;
   localparam int ADDR_W      = $clog2(MAX_OBJECTS);

   localparam int OBJ_W  = 12;
   localparam int DIST_W = 32;
   localparam int CNT_W  = 11;

   localparam int CSR_DATA_W = 12;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_PIVOT_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_PIVOT = 1'd1;

   localparam logic [CNT_W-1:0] PIVOT_COUNT_RESET = 11'd30;
   localparam logic [OBJ_W-1:0] START_PIVOT_RESET = 12'd0;

   typedef struct packed {
      logic [OBJ_W-1:0]  object_index;
      logic [DIST_W-1:0] distance;
      logic              round_last;
   } req_word_type;

   typedef struct packed {
      logic [OBJ_W-1:0]  pivot_index;
      logic [DIST_W-1:0] pivot_distance;
      logic              found;
      logic              done_res;
   } rsp_word_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [DIST_W-1:0] data;
   } dist_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } sel_wr_type;

endpackage

// ----- src/farthest_first_pivot_select.sv -----
// Farthest-first pivot selector. Each round streams one distance word per object
// (the distance to the newest pivot, Q16.16, ascending object index, round_last on
// the final word); the block keeps every object's least distance and a selected flag
// in two single-port-read RAMs and, on round_last, returns the unselected object with
// the strictly largest least distance as the next pivot. Sustained rate is one word
// per cycle while req_ready is high: a two-stage pipeline reads the distance and
// flag RAMs in stage one and does the min, compare and write-back in stage two,
// with forwarding of the previous write. Results pass through a two-word output
// buffer, and req_ready drops during the flag clear and when that buffer could overflow.
// After reset the selected-flag RAM is cleared, one entry per cycle, over all
// MAX_OBJECTS entries (4096) before the first word is accepted; register writes are
// taken during that time. After pivot_count pivots further words are accepted and dropped.
module farthest_first_pivot_select (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ffps_pkg::req_word_type              req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ffps_pkg::rsp_word_type              rsp_word,
   input  logic                                csr_wr_en,
   input  logic [ffps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ffps_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic [ffps_pkg::CNT_W-1:0]  pivot_count_ff;
   logic [ffps_pkg::OBJ_W-1:0]  start_pivot_ff;

   logic                        clear_ff;
   logic [ffps_pkg::ADDR_W-1:0] clear_addr_ff;

   logic                        s1_valid_ff;
   ffps_pkg::req_word_type      s1_word_ff;

   logic                        req_accept;
   logic [ffps_pkg::ADDR_W-1:0] rd_addr;
   logic [ffps_pkg::DIST_W-1:0] dist_q;
   logic [0:0]                  sel_q;

   ffps_pkg::dist_wr_type       dist_wr;
   ffps_pkg::sel_wr_type        sel_wr;
   logic                        sel_ram_we;
   logic [ffps_pkg::ADDR_W-1:0] sel_ram_addr;
   logic [0:0]                  sel_ram_data;

   logic                        rsp_push;
   ffps_pkg::rsp_word_type      rsp_push_word;
   logic [1:0]                  level;
   logic                        s1_res;

   assign s1_res     = s1_valid_ff && s1_word_ff.round_last;
   assign req_ready  = !clear_ff &&
                       ((level == 2'd0) || ((level == 2'd1) && (!s1_res || rsp_ready)));
   assign req_accept = req_valid && req_ready;
   assign rd_addr    = ffps_pkg::ADDR_W'(req_word.object_index);

   assign sel_ram_we   = clear_ff || sel_wr.en;
   assign sel_ram_addr = clear_ff ? clear_addr_ff : sel_wr.addr;
   assign sel_ram_data = clear_ff ? 1'b0 : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pivot_count_ff <= ffps_pkg::PIVOT_COUNT_RESET;
         start_pivot_ff <= ffps_pkg::START_PIVOT_RESET;
         clear_ff       <= 1'b1;
         clear_addr_ff  <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               ffps_pkg::CSR_PIVOT_COUNT: pivot_count_ff <= csr_data[ffps_pkg::CNT_W-1:0];
               ffps_pkg::CSR_START_PIVOT: start_pivot_ff <= csr_data[ffps_pkg::OBJ_W-1:0];
               default: begin
               end
            endcase
         end
         if (clear_ff) begin
            clear_addr_ff <= clear_addr_ff + ffps_pkg::ADDR_W'(1);
            if (clear_addr_ff == ffps_pkg::ADDR_W'(ffps_pkg::MAX_OBJECTS - 1)) begin
               clear_ff <= 1'b0;
            end
         end
         s1_valid_ff <= req_accept;
      end
      if (req_accept) begin
         s1_word_ff <= req_word;
      end
   end

   ffps_ram #(
      .WIDTH (ffps_pkg::DIST_W),
      .DEPTH (ffps_pkg::MAX_OBJECTS)
   ) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_wr.en),
      .wr_addr (dist_wr.addr),
      .wr_data (dist_wr.data),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (dist_q)
   );

   ffps_ram #(
      .WIDTH (1),
      .DEPTH (ffps_pkg::MAX_OBJECTS)
   ) u_sel_ram (
      .clock   (clock),
      .wr_en   (sel_ram_we),
      .wr_addr (sel_ram_addr),
      .wr_data (sel_ram_data),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (sel_q)
   );

   ffps_update u_update (
      .clock         (clock),
      .reset         (reset),
      .s1_valid      (s1_valid_ff),
      .s1_word       (s1_word_ff),
      .dist_q        (dist_q),
      .sel_q         (sel_q[0]),
      .pivot_count   (pivot_count_ff),
      .start_pivot   (start_pivot_ff),
      .dist_wr       (dist_wr),
      .sel_wr        (sel_wr),
      .rsp_push      (rsp_push),
      .rsp_push_word (rsp_push_word)
   );

   ffps_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_word (rsp_push_word),
      .pop       (rsp_valid && rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .level     (level)
   );

endmodule

// ----- src/ffps_ram.sv -----
module ffps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/ffps_update.sv -----
`include "farthest_first_pivot_select_defines.svh"

module ffps_update (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              s1_valid,
   input  ffps_pkg::req_word_type            s1_word,
   input  logic [ffps_pkg::DIST_W-1:0]       dist_q,
   input  logic                              sel_q,
   input  logic [ffps_pkg::CNT_W-1:0]        pivot_count,
   input  logic [ffps_pkg::OBJ_W-1:0]        start_pivot,
   output ffps_pkg::dist_wr_type             dist_wr,
   output ffps_pkg::sel_wr_type              sel_wr,
   output logic                              rsp_push,
   output ffps_pkg::rsp_word_type            rsp_push_word
);

   logic [ffps_pkg::DIST_W-1:0] best_dist_ff, best_dist_in;
   logic [ffps_pkg::OBJ_W-1:0]  best_obj_ff, best_obj_in;
   logic                        best_valid_ff, best_valid_in;
   logic [ffps_pkg::CNT_W-1:0]  chosen_ff, chosen_in;

   logic                        dfwd_valid_ff;
   logic [ffps_pkg::ADDR_W-1:0] dfwd_addr_ff;
   logic [ffps_pkg::DIST_W-1:0] dfwd_data_ff;
   logic                        sfwd_valid_ff;
   logic [ffps_pkg::ADDR_W-1:0] sfwd_addr_ff;

   logic [ffps_pkg::ADDR_W-1:0] addr;
   logic                        in_range;
   logic [ffps_pkg::DIST_W-1:0] mem_dist;
   logic                        mem_sel;
   logic                        active;
   logic                        round_end;
   logic [ffps_pkg::DIST_W-1:0] new_dist;
   logic                        taken;
   logic                        better;
   logic [ffps_pkg::DIST_W-1:0] cand_dist;
   logic [ffps_pkg::OBJ_W-1:0]  cand_obj;
   logic                        cand_valid;
   logic [ffps_pkg::CNT_W-1:0]  chosen_next;

   always_comb begin
      addr     = ffps_pkg::ADDR_W'(s1_word.object_index);
      in_range = 32'(s1_word.object_index) < 32'(ffps_pkg::MAX_OBJECTS);

      mem_dist = (dfwd_valid_ff && (dfwd_addr_ff == addr)) ? dfwd_data_ff : dist_q;
      mem_sel  = (sfwd_valid_ff && (sfwd_addr_ff == addr)) || sel_q;

      active    = s1_valid && (chosen_ff < pivot_count);
      round_end = active && s1_word.round_last;

      if (chosen_ff == ffps_pkg::CNT_W'(1)) begin
         new_dist = s1_word.distance;
      end else if (s1_word.distance < mem_dist) begin
         new_dist = s1_word.distance;
      end else begin
         new_dist = mem_dist;
      end

      taken  = mem_sel || (s1_word.object_index == start_pivot);
      better = active && in_range && !taken && (new_dist > best_dist_ff);

      cand_dist  = better ? new_dist : best_dist_ff;
      cand_obj   = better ? s1_word.object_index : best_obj_ff;
      cand_valid = better || best_valid_ff;

      chosen_next = ffps_pkg::CNT_W'(chosen_ff + ffps_pkg::CNT_W'(1));

      dist_wr.en   = active && in_range;
      dist_wr.addr = addr;
      dist_wr.data = new_dist;

      sel_wr.en   = round_end && cand_valid;
      sel_wr.addr = ffps_pkg::ADDR_W'(cand_obj);

      rsp_push                     = round_end;
      rsp_push_word.pivot_index    = cand_valid ? cand_obj : '0;
      rsp_push_word.pivot_distance = cand_valid ? cand_dist : '0;
      rsp_push_word.found          = cand_valid;
      rsp_push_word.done_res       = chosen_next >= pivot_count;

      if (round_end) begin
         best_dist_in  = '0;
         best_obj_in   = '0;
         best_valid_in = 1'b0;
         chosen_in     = chosen_next;
      end else begin
         best_dist_in  = cand_dist;
         best_obj_in   = cand_obj;
         best_valid_in = cand_valid;
         chosen_in     = chosen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_dist_ff  <= '0;
         best_obj_ff   <= '0;
         best_valid_ff <= 1'b0;
         chosen_ff     <= ffps_pkg::CNT_W'(1);
         dfwd_valid_ff <= 1'b0;
         sfwd_valid_ff <= 1'b0;
      end else begin
         best_dist_ff  <= best_dist_in;
         best_obj_ff   <= best_obj_in;
         best_valid_ff <= best_valid_in;
         chosen_ff     <= chosen_in;
         dfwd_valid_ff <= dist_wr.en;
         sfwd_valid_ff <= sel_wr.en;
      end
      dfwd_addr_ff <= dist_wr.addr;
      dfwd_data_ff <= dist_wr.data;
      sfwd_addr_ff <= sel_wr.addr;
   end

   `FFPS_ASSERT_SAME(a_found_nonzero, clock, reset, rsp_push && rsp_push_word.found,
      rsp_push_word.pivot_distance != '0, "found pivot with zero distance")
   `FFPS_ASSERT_NEXT(a_best_cleared, clock, reset, round_end,
      !best_valid_ff && (best_dist_ff == '0), "best not cleared after round end")
   `FFPS_ASSERT_NEXT(a_chosen_monotonic, clock, reset, 1'b1,
      chosen_ff >= $past(chosen_ff), "pivot count went backwards")

endmodule

// ----- src/ffps_out_fifo.sv -----
`include "farthest_first_pivot_select_defines.svh"

module ffps_out_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ffps_pkg::rsp_word_type push_word,
   input  logic                   pop,
   output logic                   rsp_valid,
   output ffps_pkg::rsp_word_type rsp_word,
   output logic [1:0]             level
);

   ffps_pkg::rsp_word_type head_ff, head_in;
   ffps_pkg::rsp_word_type skid_ff, skid_in;
   logic [1:0]             level_ff, level_in;

   always_comb begin
      head_in  = head_ff;
      skid_in  = skid_ff;
      level_in = level_ff;
      case ({push, pop})
         2'b10: begin
            if (level_ff == 2'd0) begin
               head_in = push_word;
            end else begin
               skid_in = push_word;
            end
            level_in = level_ff + 2'd1;
         end
         2'b01: begin
            head_in  = skid_ff;
            level_in = level_ff - 2'd1;
         end
         2'b11: begin
            if (level_ff == 2'd1) begin
               head_in = push_word;
            end else begin
               head_in = skid_ff;
               skid_in = push_word;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 2'd0;
      end else begin
         level_ff <= level_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = level_ff != 2'd0;
   assign rsp_word  = head_ff;
   assign level     = level_ff;

   `FFPS_ASSERT_SAME(a_no_overflow, clock, reset, push && !pop,
      level_ff != 2'd2, "push into full output buffer")
   `FFPS_ASSERT_SAME(a_pop_has_word, clock, reset, pop && (level_ff == 2'd1) && !push,
      level_in == 2'd0, "output buffer level lost track")

endmodule
